// File: rtl/flah_pkg.sv
// constants and helpers shared by the four-lane accumulator hash
`timescale 1ns / 1ps
package flah_pkg;
    localparam logic [63:0] GOLD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MULA = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] MULB = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MULC = 64'h94D049BB133111EB;
    localparam logic [5:0] ROT_RESET = 6'd31;
    localparam logic [63:0] MUL_RESET = 64'h9E3779B97F4A7C15;
    localparam logic [1:0] REG_ROT = 2'd0;
    localparam logic [1:0] REG_MUL = 2'd1;

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] k);
        logic [127:0] d;
        d = {x, x} << k;
        return d[127:64];
    endfunction
endpackage

// File: rtl/four_lane_accumulator_hash64.sv
// four-lane accumulator hash: sequencer around one shared 64x64 multiplier
//
// s_axis beats carry one 64-bit message word each plus framing; the beat
// with first set also carries seed and total length. m_axis gives one beat
// per input beat that has last set: the 64-bit hash and a length error flag.
// Configuration (rotation, multiplier) is written through cfg_we/cfg_addr/
// cfg_wdata; the user must do so only while the block is idle, as the block itself does not enforce it.
//
// Every product goes through one shared multiplier built from three 32x32
// partial products taken one per cycle. After a beat is taken s_axis_tready
// stays low while the block works on it; a word that folds into the
// accumulator takes one product, and a first beat adds its five setup
// products. A last beat adds the cross-mix and three-product finalizer
// (with one more product for a tail fold); an error result skips them,
// and the result beat follows.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new beat. aresetn (synchronous, low) clears
// the lane, accumulator, length and flag registers and the state, and restores the register reset values.
`timescale 1ns / 1ps
module four_lane_accumulator_hash64 (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // data_word[63:0], byte_count[67:64], seed[131:68], message_length[163:132], pad
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // last
    input  logic         s_axis_tuser,   // first
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // hash_value
    output logic         m_axis_tuser,   // length_error
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);
    typedef enum logic [4:0] {
        S_IDLE, S_BASE, S_L1, S_L2, S_L3, S_L4, S_CHECK, S_WORD, S_FOLDM,
        S_FIN0, S_TAILM, S_MIX, S_F1, S_F2, S_F3, S_OUT
    } state_t;

    state_t state_reg;
    logic [5:0]  rot_reg;
    logic [63:0] mulc_reg;
    logic [63:0] l1_reg, l2_reg, l3_reg, l4_reg, acc_reg, par_reg, base_reg;
    logic [31:0] off_reg, exp_reg;
    logic        seen_reg, err_reg;
    logic [63:0] word_reg, tail_reg, fx_reg, out_reg, seed_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg, oerr_reg, outv_reg;

    // shared multiplier: three 32x32 partial products, one per cycle
    logic [63:0] mx_reg, my_reg, prod_reg;
    logic [1:0]  mstep_reg;
    logic        mbusy_reg, mdone_reg;
    logic        mstart;
    logic [63:0] mx_in, my_in;
    logic [31:0] pa, pb;
    logic [63:0] pp;

    assign pa = mstep_reg[0] ? mx_reg[63:32] : mx_reg[31:0];
    assign pb = mstep_reg[1] ? my_reg[63:32] : my_reg[31:0];
    assign pp = {32'd0, pa} * {32'd0, pb};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            mstep_reg <= 2'd0;
        end else begin
            mdone_reg <= 1'b0;
            if (mstart) begin
                mx_reg <= mx_in;
                my_reg <= my_in;
                prod_reg <= 64'd0;
                mstep_reg <= 2'd0;
                mbusy_reg <= 1'b1;
            end else if (mbusy_reg) begin
                case (mstep_reg)
                    2'd0: prod_reg <= prod_reg + pp;
                    2'd1: prod_reg <= prod_reg + {pp[31:0], 32'd0};
                    2'd2: prod_reg <= prod_reg + {pp[31:0], 32'd0};
                    default: prod_reg <= prod_reg;
                endcase
                mstep_reg <= mstep_reg + 2'd1;
                if (mstep_reg == 2'd2) begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
        end
    end

    logic [63:0] in_word, in_seed;
    logic [3:0]  in_cnt;
    logic [31:0] in_len;
    assign in_word = s_axis_tdata[63:0];
    assign in_cnt  = s_axis_tdata[67:64];
    assign in_seed = s_axis_tdata[131:68];
    assign in_len  = s_axis_tdata[163:132];

    assign s_axis_tready = (state_reg == S_IDLE) && !outv_reg;
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = oerr_reg;

    // checks and word absorb, combinational off the held beat
    logic [31:0] room, grp_end;
    logic        bad, in_grp;
    logic [1:0]  slot;
    logic [63:0] fold_x, fold_t;
    assign room    = exp_reg - off_reg;
    assign bad     = (cnt_reg > 4'd8) || (!last_reg && cnt_reg != 4'd8)
                   || ({28'd0, cnt_reg} > room);
    assign grp_end = {exp_reg[31:5], 5'd0};
    assign in_grp  = off_reg < grp_end;
    assign slot    = off_reg[4:3];
    assign fold_x  = flah_pkg::rotl(acc_reg ^ fx_reg, rot_reg);
    assign fold_t  = flah_pkg::rotl(acc_reg ^ tail_reg, rot_reg);

    logic [63:0] fa, fb, fm;
    assign fb = flah_pkg::rotl(l2_reg ^ l1_reg, 6'd43);
    assign fa = l1_reg ^ fb;
    assign fm = flah_pkg::rotl((fa ^ tail_reg) + fb, 6'd11);

    // finalizer input uses scratch accumulator held in fx_reg
    logic [63:0] mixa_fin;
    always_comb begin
        mixa_fin = (tail_reg != 64'd0) ? fm : fa;
        mixa_fin = mixa_fin ^ fb ^ (l3_reg ^ l4_reg);
        if (seen_reg) mixa_fin = mixa_fin ^ fx_reg;
        mixa_fin = mixa_fin ^ (mixa_fin >> 29);
    end

    always_comb begin
        mstart = 1'b0;
        mx_in = base_reg;
        my_in = flah_pkg::GOLD;
        case (state_reg)
            S_IDLE:  if (s_axis_tvalid && s_axis_tready && s_axis_tuser) begin
                mstart = 1'b1;
                mx_in = {32'd0, in_len};
            end
            S_BASE:  if (mdone_reg) begin
                mstart = 1'b1;
                mx_in = seed_reg ^ prod_reg;
            end
            S_L1:    if (mdone_reg) begin mstart = 1'b1; my_in = flah_pkg::MULA; end
            S_L2:    if (mdone_reg) begin mstart = 1'b1; my_in = flah_pkg::MULB; end
            S_L3:    if (mdone_reg) begin mstart = 1'b1; my_in = flah_pkg::MULC; end
            S_WORD:  begin mstart = 1'b1; mx_in = fold_x; my_in = mulc_reg; end
            S_FIN0:  if (!err_reg && off_reg == exp_reg && tail_reg != 64'd0 && seen_reg) begin
                mstart = 1'b1; mx_in = fold_t; my_in = mulc_reg;
            end
            S_MIX:   begin mstart = 1'b1; mx_in = mixa_fin; my_in = flah_pkg::MULA; end
            S_F1:    if (mdone_reg) begin
                mstart = 1'b1; mx_in = prod_reg ^ (prod_reg >> 31); my_in = flah_pkg::MULB;
            end
            S_F2:    if (mdone_reg) begin
                mstart = 1'b1; mx_in = prod_reg ^ (prod_reg >> 37); my_in = flah_pkg::GOLD;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rot_reg <= flah_pkg::ROT_RESET;
            mulc_reg <= flah_pkg::MUL_RESET;
            l1_reg <= '0; l2_reg <= '0; l3_reg <= '0; l4_reg <= '0;
            acc_reg <= '0; par_reg <= '0; off_reg <= '0; exp_reg <= '0;
            seen_reg <= 1'b0; err_reg <= 1'b0; outv_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == flah_pkg::REG_ROT) rot_reg <= cfg_wdata[5:0];
                else if (cfg_addr == flah_pkg::REG_MUL) mulc_reg <= cfg_wdata;
            end
            if (outv_reg && m_axis_tready) outv_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    word_reg <= in_word;
                    cnt_reg <= in_cnt;
                    last_reg <= s_axis_tlast;
                    seed_reg <= in_seed;
                    tail_reg <= '0;
                    if (s_axis_tuser) begin
                        exp_reg <= in_len;
                        state_reg <= S_BASE;
                    end else begin
                        state_reg <= S_CHECK;
                    end
                end
                S_BASE: if (mdone_reg) begin
                    base_reg <= seed_reg ^ prod_reg;
                    state_reg <= S_L1;
                end
                S_L1: if (mdone_reg) begin l1_reg <= prod_reg; state_reg <= S_L2; end
                S_L2: if (mdone_reg) begin l2_reg <= prod_reg; state_reg <= S_L3; end
                S_L3: if (mdone_reg) begin l3_reg <= prod_reg; state_reg <= S_L4; end
                S_L4: if (mdone_reg) begin
                    l4_reg <= prod_reg;
                    acc_reg <= base_reg ^ flah_pkg::MULB;
                    par_reg <= '0; off_reg <= '0;
                    seen_reg <= 1'b0; err_reg <= 1'b0;
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    state_reg <= last_reg ? S_FIN0 : S_IDLE;
                    if (bad) begin
                        err_reg <= 1'b1;
                    end else if (cnt_reg == 4'd8) begin
                        off_reg <= off_reg + 32'd8;
                        seen_reg <= 1'b1;
                        if (in_grp) begin
                            case (slot)
                                2'd0: begin
                                    l1_reg <= flah_pkg::rotl((l1_reg ^ word_reg) + l2_reg, 6'd11);
                                    par_reg <= word_reg;
                                end
                                2'd1: begin
                                    l2_reg <= flah_pkg::rotl((l2_reg ^ word_reg) + l3_reg, 6'd17);
                                    par_reg <= par_reg ^ word_reg;
                                end
                                2'd2: begin
                                    l3_reg <= flah_pkg::rotl((l3_reg ^ word_reg) + l4_reg, 6'd23);
                                    par_reg <= par_reg ^ word_reg;
                                end
                                default: begin
                                    l4_reg <= flah_pkg::rotl((l4_reg ^ word_reg) + l1_reg, 6'd57);
                                    fx_reg <= par_reg ^ word_reg;
                                    par_reg <= '0;
                                    state_reg <= S_WORD;
                                end
                            endcase
                        end else begin
                            l1_reg <= flah_pkg::rotl((l1_reg ^ word_reg) + l2_reg, 6'd11);
                            fx_reg <= word_reg;
                            state_reg <= S_WORD;
                        end
                    end else if (cnt_reg != 4'd0) begin
                        off_reg <= off_reg + {28'd0, cnt_reg};
                        tail_reg <= word_reg & ((64'd1 << {cnt_reg[2:0], 3'd0}) - 64'd1);
                    end
                end
                S_WORD: state_reg <= S_FOLDM;
                S_FOLDM: if (mdone_reg) begin
                    acc_reg <= prod_reg;
                    state_reg <= last_reg ? S_FIN0 : S_IDLE;
                end
                S_FIN0: begin
                    // error check, then tail fold (or plain copy) into a scratch copy of the accumulator
                    if (err_reg || off_reg != exp_reg) begin
                        out_reg <= '0; oerr_reg <= 1'b1; outv_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else if (tail_reg != 64'd0 && seen_reg) begin
                        state_reg <= S_TAILM;
                    end else begin
                        fx_reg <= acc_reg;
                        state_reg <= S_MIX;
                    end
                end
                S_TAILM: if (mdone_reg) begin
                    fx_reg <= prod_reg;
                    state_reg <= S_MIX;
                end
                S_MIX: state_reg <= S_F1;
                S_F1: if (mdone_reg) state_reg <= S_F2;
                S_F2: if (mdone_reg) state_reg <= S_F3;
                S_F3: if (mdone_reg) begin
                    out_reg <= prod_reg ^ (prod_reg >> 41);
                    oerr_reg <= 1'b0; outv_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (!outv_reg || m_axis_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted a beat while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("error result with nonzero hash");
    assert property (@(posedge aclk) disable iff (!aresetn)
        mstart |-> !mbusy_reg)
        else $error("multiplier restarted while busy");
endmodule
